// File: rtl/core/nnue_acc_pkg.sv
package nnue_acc_pkg;

    localparam int MAX_FEATURES_DEF   = 64 * 10 * 64;
    localparam int MAX_HIDDEN_ONE_DEF = 256;
    localparam int SCORE_LIMIT_DEF    = 31753;
    localparam int HIDDEN_TWO         = 32;
    localparam int HT_W               = $clog2(HIDDEN_TWO);
    localparam int FEAT_W             = 16;
    localparam int TOT_W              = 56;
    localparam int DVS_W              = 45;
    localparam int SUM_W              = 48;

    localparam logic [2:0] FN_WRITE   = 3'd0;
    localparam logic [2:0] FN_REFRESH = 3'd1;
    localparam logic [2:0] FN_ADD     = 3'd2;
    localparam logic [2:0] FN_PUT     = 3'd3;
    localparam logic [2:0] FN_REMOVE  = 3'd4;
    localparam logic [2:0] FN_EVAL    = 3'd5;

    localparam logic [2:0] RG_FEAT  = 3'd0;
    localparam logic [2:0] RG_FBIAS = 3'd1;
    localparam logic [2:0] RG_SW    = 3'd2;
    localparam logic [2:0] RG_SBIAS = 3'd3;
    localparam logic [2:0] RG_OUTW  = 3'd4;

    localparam logic [2:0] CFG_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_WIDE     = 3'd1;
    localparam logic [2:0] CFG_ACT      = 3'd2;
    localparam logic [2:0] CFG_HID      = 3'd3;
    localparam logic [2:0] CFG_OUT      = 3'd4;
    localparam logic [2:0] CFG_OUT_BIAS = 3'd5;
    localparam logic [2:0] CFG_LOADED   = 3'd6;

    localparam logic [1:0] FMT_UNCLIPPED = 2'd0;
    localparam logic [1:0] FMT_BUCKET    = 2'd3;

    localparam logic [2:0] KIND_KING = 3'd5;

    typedef struct packed {
        logic                    start;
        logic signed [TOT_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [TOT_W-1:0] quot;
        logic signed [DVS_W:0]   rem;
    } t_div_rsp;

endpackage

// File: rtl/core/nnue_acc_in_if.sv
interface nnue_acc_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [2:0]        region;
    logic [23:0]       address;
    logic signed [15:0] data;
    logic [2:0]        piece_kind;
    logic              piece_color;
    logic [5:0]        square;
    logic [5:0]        white_king_square;
    logic [5:0]        black_king_square;
    logic              side_to_move;

    modport source (
        output valid, func, region, address, data, piece_kind, piece_color, square,
               white_king_square, black_king_square, side_to_move,
        input  ready
    );
    modport sink (
        input  valid, func, region, address, data, piece_kind, piece_color, square,
               white_king_square, black_king_square, side_to_move,
        output ready
    );
endinterface

// File: rtl/core/nnue_acc_out_if.sv
interface nnue_acc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] score;
    logic               score_valid;

    modport source (output valid, score, score_valid, input ready);
    modport sink (input valid, score, score_valid, output ready);
endinterface

// File: rtl/core/nnue_acc_div.sv
module nnue_acc_div
    import nnue_acc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(TOT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TOT_W-1:0] r_num;
    logic [TOT_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic             r_neg;

    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_num[TOT_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_req.dividend[TOT_W-1];
                r_num  <= i_req.dividend[TOT_W-1] ? TOT_W'(-i_req.dividend)
                                                  : TOT_W'(i_req.dividend);
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
                r_quo <= {r_quo[TOT_W-2:0], fits};
                r_num <= {r_num[TOT_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_rsp.rem  = r_neg ? -$signed({1'b0, r_rem}) : $signed({1'b0, r_rem});

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("divider done without a run");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider started while busy");

endmodule

// File: rtl/core/nnue_accumulator_and_eval_top.sv
// Weight write, ignored item and unloaded refresh: handled in the idle state.
// Refresh start (H = 128 or 256): one first-layer bias word a cycle.
// Put, remove, refresh add: one accumulator word a cycle.
// Evaluate: 32 rows of N = H or 2H inputs, one multiply-accumulate a cycle,
// then a shift-subtract divider; the rounded score goes to the output register.
// Reset clears control and king squares, sets default config, marks accumulators invalid.
module nnue_accumulator_and_eval_top
    import nnue_acc_pkg::*;
#(
    parameter int MAX_FEATURES   = MAX_FEATURES_DEF,
    parameter int MAX_HIDDEN_ONE = MAX_HIDDEN_ONE_DEF,
    parameter int SCORE_LIMIT    = SCORE_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nnue_acc_in_if.sink           i_item,
    nnue_acc_out_if.source        o_result,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    localparam int HW       = $clog2(MAX_HIDDEN_ONE);
    localparam int H_WIDE   = (MAX_HIDDEN_ONE < 256) ? MAX_HIDDEN_ONE : 256;
    localparam int H_NARROW = 128;
    localparam int FW_DEPTH = MAX_FEATURES * MAX_HIDDEN_ONE;
    localparam int FW_AW    = $clog2(FW_DEPTH);
    localparam int SW_DEPTH = HIDDEN_TWO * 2 * MAX_HIDDEN_ONE;
    localparam int SW_AW    = $clog2(SW_DEPTH);
    localparam int PB_W     = FEAT_W + HW + 1;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_REFRESH = 15'b000000000000010,
        S_PSETUP  = 15'b000000000000100,
        S_PIECE   = 15'b000000000001000,
        S_ESETUP  = 15'b000000000010000,
        S_EROW    = 15'b000000000100000,
        S_EBIAS   = 15'b000000001000000,
        S_EMAC    = 15'b000000010000000,
        S_EHID    = 15'b000000100000000,
        S_EPROD   = 15'b000001000000000,
        S_EACC    = 15'b000010000000000,
        S_DSTART  = 15'b000100000000000,
        S_DIV     = 15'b001000000000000,
        S_ROUND   = 15'b010000000000000,
        S_FINISH  = 15'b100000000000000
    } t_state;

    t_state r_state;

    logic [1:0]         r_net_format;
    logic               r_hidden_wide;
    logic [14:0]        r_act_scale;
    logic [14:0]        r_hidden_scale;
    logic [14:0]        r_out_scale;
    logic signed [31:0] r_out_bias;
    logic               r_net_loaded;

    logic [5:0] r_ks_w;
    logic [5:0] r_ks_b;
    logic       r_acc_valid;

    logic [2:0] r_kind;
    logic       r_color;
    logic [5:0] r_sq;
    logic       r_sub;
    logic       r_stm;

    logic [HW:0]      r_h;
    logic [HW:0]      r_i;
    logic             r_p;
    logic             r_rd_v;
    logic [HW-1:0]    r_wi;
    logic [FW_AW-1:0] r_base;

    logic [14:0]             r_s0;
    logic [14:0]             r_s2;
    logic [29:0]             r_den1;
    logic [DVS_W-1:0]        r_d;
    logic [HT_W-1:0]         r_j;
    logic [SW_AW-1:0]        r_swa;
    logic [1:0]              r_k;
    logic                    r_rp;
    logic                    r_v2;
    logic signed [31:0]      r_prod;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [31:0]      r_hv;
    logic signed [47:0]      r_oprod;
    logic signed [TOT_W-1:0] r_tot;

    logic signed [15:0] r_score;
    logic               r_score_valid;
    logic               r_out_valid;
    logic signed [15:0] r_out_score;
    logic               r_out_sv;

    logic [15:0] fw_mem [FW_DEPTH];
    logic [15:0] fb_mem [MAX_HIDDEN_ONE];
    logic [15:0] sw_mem [SW_DEPTH];
    logic [15:0] sb_mem [HIDDEN_TWO];
    logic [15:0] ow_mem [HIDDEN_TWO];
    logic [15:0] accw_mem [MAX_HIDDEN_ONE];
    logic [15:0] accb_mem [MAX_HIDDEN_ONE];

    logic [15:0] r_fw_q;
    logic [15:0] r_fb_q;
    logic [15:0] r_sw_q;
    logic [15:0] r_sb_q;
    logic [15:0] r_ow_q;
    logic [15:0] r_accw_q;
    logic [15:0] r_accb_q;

    logic        in_fire;
    logic [31:0] addr32;
    logic        fw_we, fb_we, sw_we, sb_we, ow_we;
    logic        accw_we, accb_we;
    logic [15:0] acc_wd;
    logic [FW_AW-1:0] fw_ra;

    logic        fmt3;
    logic        clipped;
    logic [1:0]  halves;
    logic [HW:0] h_sel;
    logic [14:0] s0_c, s1_c, s2_c;

    logic [2:0]        rank_flip;
    logic [5:0]        rsq, rks;
    logic              rel;
    logic [9:0]        bucket;
    logic [3:0]        plain_row;
    logic [FEAT_W-1:0] f_idx;
    logic              feat_ok;
    logic [PB_W-1:0]   base_full;

    logic [15:0]        acc_sel;
    logic signed [15:0] clip_v;
    logic signed [31:0] hv_c;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic signed [TOT_W:0]  b_full;
    logic signed [18:0]     b_small;
    logic [DVS_W-1:0]       hd;
    logic signed [DVS_W+1:0] x_pos, x_neg;
    logic signed [1:0]      adj;
    logic signed [18:0]     cp;
    logic signed [15:0]     rnd_score;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign addr32       = 32'(i_item.address);

    assign fmt3    = (r_net_format == FMT_BUCKET);
    assign clipped = (r_net_format != FMT_UNCLIPPED);
    assign halves  = r_net_format[1] ? 2'd2 : 2'd1;
    assign h_sel   = r_hidden_wide ? (HW+1)'(H_WIDE) : (HW+1)'(H_NARROW);
    assign s0_c    = (r_act_scale == '0) ? 15'd1 : r_act_scale;
    assign s1_c    = (r_hidden_scale == '0) ? 15'd1 : r_hidden_scale;
    assign s2_c    = (r_out_scale == '0) ? 15'd1 : r_out_scale;

    assign fw_we = in_fire && i_item.func == FN_WRITE && i_item.region == RG_FEAT
                   && addr32 < 32'(FW_DEPTH);
    assign fb_we = in_fire && i_item.func == FN_WRITE && i_item.region == RG_FBIAS
                   && addr32 < 32'(MAX_HIDDEN_ONE);
    assign sw_we = in_fire && i_item.func == FN_WRITE && i_item.region == RG_SW
                   && addr32 < 32'(SW_DEPTH);
    assign sb_we = in_fire && i_item.func == FN_WRITE && i_item.region == RG_SBIAS
                   && addr32 < 32'(HIDDEN_TWO);
    assign ow_we = in_fire && i_item.func == FN_WRITE && i_item.region == RG_OUTW
                   && addr32 < 32'(HIDDEN_TWO);

    // feature index of the latched piece for perspective r_p
    assign rank_flip = r_p ? 3'b111 : 3'b000;
    assign rsq       = r_sq ^ {rank_flip, 3'b000};
    assign rks       = (r_p ? r_ks_b : r_ks_w) ^ {rank_flip, 3'b000};
    assign rel       = (r_color != r_p);
    assign bucket    = 10'(rks) * 10'd10 + (rel ? 10'd5 : 10'd0) + 10'(r_kind);
    assign plain_row = (rel ? 4'd6 : 4'd0) + 4'(r_kind);
    assign f_idx     = fmt3 ? {bucket, rsq} : {6'b000000, plain_row, rsq};
    assign feat_ok   = (r_kind <= KIND_KING) && !(fmt3 && r_kind == KIND_KING)
                       && (32'(f_idx) < 32'(MAX_FEATURES));
    assign base_full = PB_W'(f_idx) * PB_W'(r_h);

    assign fw_ra = r_base + FW_AW'(r_i);

    always_comb begin
        accw_we = 1'b0;
        accb_we = 1'b0;
        acc_wd  = r_fb_q;
        if (r_state == S_REFRESH && r_rd_v) begin
            accw_we = 1'b1;
            accb_we = 1'b1;
        end else if (r_state == S_PIECE && r_rd_v) begin
            accw_we = !r_p;
            accb_we = r_p;
            acc_wd  = r_sub ? (acc_sel - r_fw_q) : (acc_sel + r_fw_q);
        end
    end

    assign acc_sel = (r_state == S_PIECE ? r_p : r_rp) ? r_accb_q : r_accw_q;

    always_comb begin
        if (acc_sel[15]) begin
            clip_v = 16'sd0;
        end else if (clipped && acc_sel[14:0] > r_s0) begin
            clip_v = $signed({1'b0, r_s0});
        end else begin
            clip_v = $signed(acc_sel);
        end
    end

    always_comb begin
        if (r_sum < 0) begin
            hv_c = 32'sd0;
        end else if (clipped && r_sum > $signed(SUM_W'(r_den1))) begin
            hv_c = $signed(32'(r_den1));
        end else begin
            hv_c = r_sum[31:0];
        end
    end

    // rounding half away from zero on (out_bias + q) * d + r, without the product
    always_comb begin
        b_full  = $signed(TOT_W'(r_out_bias)) + div_rsp.quot;
        b_small = b_full[18:0];
        hd      = r_d >> 1;
        x_pos   = $signed((DVS_W+2)'(div_rsp.rem)) + $signed({2'b00, hd});
        x_neg   = $signed({2'b00, hd}) - $signed((DVS_W+2)'(div_rsp.rem));
        if (b_small > 0 || (b_small == 0 && !div_rsp.rem[DVS_W])) begin
            if (x_pos < 0) begin
                adj = -2'sd1;
            end else if (x_pos >= $signed({2'b00, r_d})) begin
                adj = 2'sd1;
            end else begin
                adj = 2'sd0;
            end
            cp = b_small + 19'(adj);
        end else begin
            if (x_neg < 0) begin
                adj = -2'sd1;
            end else if (x_neg >= $signed({2'b00, r_d})) begin
                adj = 2'sd1;
            end else begin
                adj = 2'sd0;
            end
            cp = b_small - 19'(adj);
        end
        if (b_full > $signed((TOT_W+1)'(65536))) begin
            rnd_score = 16'(SCORE_LIMIT);
        end else if (b_full < -$signed((TOT_W+1)'(65536))) begin
            rnd_score = -16'(SCORE_LIMIT);
        end else if (cp > $signed(19'(SCORE_LIMIT))) begin
            rnd_score = 16'(SCORE_LIMIT);
        end else if (cp < -$signed(19'(SCORE_LIMIT))) begin
            rnd_score = -16'(SCORE_LIMIT);
        end else begin
            rnd_score = cp[15:0];
        end
    end

    assign div_req.start    = (r_state == S_DSTART);
    assign div_req.dividend = r_tot;
    assign div_req.divisor  = r_d;

    nnue_acc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (fw_we) begin
            fw_mem[i_item.address[FW_AW-1:0]] <= i_item.data;
        end
        r_fw_q <= fw_mem[fw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb_mem[i_item.address[HW-1:0]] <= i_item.data;
        end
        r_fb_q <= fb_mem[r_i[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sw_we) begin
            sw_mem[i_item.address[SW_AW-1:0]] <= i_item.data;
        end
        r_sw_q <= sw_mem[r_swa];
    end

    always_ff @(posedge i_clk) begin
        if (sb_we) begin
            sb_mem[i_item.address[HT_W-1:0]] <= i_item.data;
        end
        r_sb_q <= sb_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (ow_we) begin
            ow_mem[i_item.address[HT_W-1:0]] <= i_item.data;
        end
        r_ow_q <= ow_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (accw_we) begin
            accw_mem[r_wi] <= acc_wd;
        end
        r_accw_q <= accw_mem[r_i[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accb_we) begin
            accb_mem[r_wi] <= acc_wd;
        end
        r_accb_q <= accb_mem[r_i[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_net_format   <= 2'd1;
            r_hidden_wide  <= 1'b1;
            r_act_scale    <= 15'd1;
            r_hidden_scale <= 15'd1;
            r_out_scale    <= 15'd1;
            r_out_bias     <= '0;
            r_net_loaded   <= 1'b0;
            r_ks_w         <= '0;
            r_ks_b         <= '0;
            r_acc_valid    <= 1'b0;
            r_rd_v         <= 1'b0;
            r_v2           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FORMAT:   r_net_format   <= i_cfg_data[1:0];
                    CFG_WIDE:     r_hidden_wide  <= i_cfg_data[0];
                    CFG_ACT:      r_act_scale    <= i_cfg_data[14:0];
                    CFG_HID:      r_hidden_scale <= i_cfg_data[14:0];
                    CFG_OUT:      r_out_scale    <= i_cfg_data[14:0];
                    CFG_OUT_BIAS: r_out_bias     <= $signed(i_cfg_data);
                    CFG_LOADED:   r_net_loaded   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind  <= i_item.piece_kind;
                        r_color <= i_item.piece_color;
                        r_sq    <= i_item.square;
                        r_stm   <= i_item.side_to_move;
                        r_sub   <= (i_item.func == FN_REMOVE);
                        r_p     <= 1'b0;
                        r_h     <= h_sel;
                        r_i     <= '0;
                        r_rd_v  <= 1'b0;
                        case (i_item.func)
                            FN_REFRESH: begin
                                if (!r_net_loaded) begin
                                    r_acc_valid <= 1'b0;
                                end else begin
                                    r_ks_w  <= i_item.white_king_square;
                                    r_ks_b  <= i_item.black_king_square;
                                    r_state <= S_REFRESH;
                                end
                            end
                            FN_ADD: begin
                                if (r_net_loaded) begin
                                    r_state <= S_PSETUP;
                                end
                            end
                            FN_PUT, FN_REMOVE: begin
                                if (r_net_loaded && r_acc_valid) begin
                                    if (fmt3 && i_item.piece_kind == KIND_KING) begin
                                        r_acc_valid <= 1'b0;
                                    end else begin
                                        r_state <= S_PSETUP;
                                    end
                                end
                            end
                            FN_EVAL: begin
                                if (r_net_loaded && r_acc_valid) begin
                                    r_state <= S_ESETUP;
                                end else begin
                                    r_score       <= '0;
                                    r_score_valid <= 1'b0;
                                    r_state       <= S_FINISH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_REFRESH: begin
                    if (r_i < r_h) begin
                        r_i    <= r_i + 1'b1;
                        r_wi   <= r_i[HW-1:0];
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) begin
                            r_acc_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end

                S_PSETUP: begin
                    r_i    <= '0;
                    r_rd_v <= 1'b0;
                    if (feat_ok) begin
                        r_base  <= FW_AW'(base_full);
                        r_state <= S_PIECE;
                    end else if (!r_p) begin
                        r_p <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end

                S_PIECE: begin
                    if (r_i < r_h) begin
                        r_i    <= r_i + 1'b1;
                        r_wi   <= r_i[HW-1:0];
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) begin
                            if (!r_p) begin
                                r_p     <= 1'b1;
                                r_state <= S_PSETUP;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end

                S_ESETUP: begin
                    r_s0    <= s0_c;
                    r_s2    <= s2_c;
                    r_den1  <= 30'(s0_c) * 30'(s1_c);
                    r_j     <= '0;
                    r_swa   <= '0;
                    r_tot   <= '0;
                    r_state <= S_EROW;
                end

                S_EROW: begin
                    r_d     <= DVS_W'(r_s2) * DVS_W'(r_den1);
                    r_state <= S_EBIAS;
                end

                S_EBIAS: begin
                    r_sum   <= SUM_W'($signed(r_sb_q) * $signed({1'b0, r_s0}));
                    r_i     <= '0;
                    r_k     <= '0;
                    r_rd_v  <= 1'b0;
                    r_v2    <= 1'b0;
                    r_state <= S_EMAC;
                end

                S_EMAC: begin
                    if (r_k != halves) begin
                        r_rp   <= (r_k != 2'd0) ? !r_stm : r_stm;
                        r_rd_v <= 1'b1;
                        r_swa  <= r_swa + 1'b1;
                        if (r_i == r_h - 1'b1) begin
                            r_i <= '0;
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    r_v2 <= r_rd_v;
                    if (r_rd_v) begin
                        r_prod <= $signed(r_sw_q) * clip_v;
                    end
                    if (r_v2) begin
                        r_sum <= r_sum + SUM_W'(r_prod);
                    end
                    if (r_k == halves && !r_rd_v && !r_v2) begin
                        r_state <= S_EHID;
                    end
                end

                S_EHID: begin
                    r_hv    <= hv_c;
                    r_state <= S_EPROD;
                end

                S_EPROD: begin
                    r_oprod <= $signed(r_ow_q) * r_hv;
                    r_state <= S_EACC;
                end

                S_EACC: begin
                    r_tot <= r_tot + TOT_W'(r_oprod);
                    r_j   <= r_j + 1'b1;
                    if (r_j == HT_W'(HIDDEN_TWO - 1)) begin
                        r_state <= S_DSTART;
                    end else begin
                        r_state <= S_EROW;
                    end
                end

                S_DSTART: begin
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_ROUND;
                    end
                end

                S_ROUND: begin
                    r_score       <= rnd_score;
                    r_score_valid <= 1'b1;
                    r_state       <= S_FINISH;
                end

                S_FINISH: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_score;
                        r_out_sv    <= r_score_valid;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.score       = r_out_score;
    assign o_result.score_valid = r_out_sv;

    a_unloaded_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_item.func == FN_REFRESH && !r_net_loaded) |=> !r_acc_valid)
        else $error("refresh while unloaded kept accumulators valid");
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ($signed(o_result.score) <= $signed(16'(SCORE_LIMIT))
                         && $signed(o_result.score) >= -$signed(16'(SCORE_LIMIT))))
        else $error("score beyond limit");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.score_valid) |-> (o_result.score == '0))
        else $error("invalid score not zero");
    a_acc_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accw_we || accb_we) |-> (r_state == S_REFRESH || r_state == S_PIECE))
        else $error("accumulator written outside an update");
    a_div_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_rsp.done) |=> (r_state == S_ROUND))
        else $error("division result missed");

endmodule

// File: tb/nnue_accumulator_and_eval_top_tb.sv
module nnue_accumulator_and_eval_top_tb;
    import nnue_acc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 600;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int NUM_PHASES     = 8;
    localparam int POOL_N         = 10;
    localparam int FEAT_DEPTH     = MAX_FEATURES_DEF * MAX_HIDDEN_ONE_DEF;
    localparam int SW_DEPTH       = HIDDEN_TWO * 2 * MAX_HIDDEN_ONE_DEF;

    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;
    localparam logic [2:0] RG_SPARE   = 3'd5;
    localparam logic [1:0] FMT_CLIPPED = 2'd1;
    localparam logic [1:0] FMT_DUAL    = 2'd2;

    typedef struct {
        logic [2:0]         func;
        logic [2:0]         region;
        logic [23:0]        address;
        logic signed [15:0] data;
        logic [2:0]         kind;
        logic               color;
        logic [5:0]         square;
        logic [5:0]         wk;
        logic [5:0]         bk;
        logic               stm;
    } board_item_t;

    typedef struct {
        logic signed [15:0] score;
        logic               valid;
    } eval_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e   rk;
        board_item_t it;
        logic [2:0]  cfg_idx;
        logic [31:0] cfg_val;
        bit          typed;
        eval_t       want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    nnue_acc_in_if  item_if();
    nnue_acc_out_if res_if();

    nnue_accumulator_and_eval_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    logic [15:0] feat_mem [int unsigned];
    logic [15:0] fbias  [MAX_HIDDEN_ONE_DEF];
    logic [15:0] sw_mem [SW_DEPTH];
    logic [15:0] sbias  [HIDDEN_TWO];
    logic [15:0] outw   [HIDDEN_TWO];
    logic [15:0] acc    [2][MAX_HIDDEN_ONE_DEF];
    logic [5:0]  ksq    [2];
    bit          acc_ok;

    logic [1:0]  p_fmt;
    bit          p_wide;
    int          p_act, p_hid, p_out;
    longint      p_bias;
    bit          p_loaded;

    eval_t       pending_scores[$];
    eval_t       got_want;
    dir_row_t    dir_rows[$];
    int          fails;
    int          n_items;
    int          n_writes;
    int          n_scores;
    int          quiet;
    int          stall_left;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int hid_n();
        return p_wide ? 256 : 128;
    endfunction

    function automatic bit feat_index(input logic [2:0] kind, input logic color,
                                      input logic [5:0] sq, input int p, output int f);
        logic [5:0] s;
        logic [5:0] k;
        int         rel;
        s   = sq ^ (p != 0 ? 6'd56 : 6'd0);
        k   = ksq[p] ^ (p != 0 ? 6'd56 : 6'd0);
        rel = (int'(color) != p) ? 1 : 0;
        f   = 0;
        if (kind > KIND_KING) return 0;
        if (p_fmt == FMT_BUCKET) begin
            if (kind == KIND_KING) return 0;
            f = ((int'(k) * 10 + rel * 5 + int'(kind)) * 64) + int'(s);
        end else begin
            f = (rel * 6 + int'(kind)) * 64 + int'(s);
        end
        return f < MAX_FEATURES_DEF;
    endfunction

    function automatic void apply_piece(input logic [2:0] kind, input logic color,
                                        input logic [5:0] sq, input bit sub);
        int f;
        int h;
        logic [15:0] w;
        h = hid_n();
        for (int p = 0; p < 2; p++) begin
            if (!feat_index(kind, color, sq, p, f)) continue;
            for (int i = 0; i < h; i++) begin
                w = feat_mem[f * h + i];
                acc[p][i] = sub ? acc[p][i] - w : acc[p][i] + w;
            end
        end
    endfunction

    function automatic logic signed [15:0] predict_score(input logic stm);
        int     h, n_in, halves, p;
        bit     clipped;
        longint s0, s1, s2, den1, d, tot, sum, v, hv, q, r, b, t, cp;
        h       = hid_n();
        clipped = p_fmt != FMT_UNCLIPPED;
        halves  = (p_fmt >= FMT_DUAL) ? 2 : 1;
        n_in    = halves * h;
        s0      = (p_act == 0) ? 1 : p_act;
        s1      = (p_hid == 0) ? 1 : p_hid;
        s2      = (p_out == 0) ? 1 : p_out;
        den1    = s0 * s1;
        d       = s2 * den1;
        tot     = 0;
        for (int j = 0; j < HIDDEN_TWO; j++) begin
            sum = longint'($signed(sbias[j])) * s0;
            for (int k = 0; k < halves; k++) begin
                p = (k != 0) ? int'(~stm) : int'(stm);
                for (int i = 0; i < h; i++) begin
                    v = longint'($signed(acc[p][i]));
                    if (v < 0) v = 0;
                    else if (clipped && v > s0) v = s0;
                    sum += longint'($signed(sw_mem[j * n_in + k * h + i])) * v;
                end
            end
            if (sum < 0) sum = 0;
            else if (clipped && sum > den1) sum = den1;
            hv = longint'($signed(sum[31:0]));
            tot += longint'($signed(outw[j])) * hv;
        end
        q = tot / d;
        r = tot % d;
        b = p_bias + q;
        if (b > 65536) return 16'(SCORE_LIMIT_DEF);
        if (b < -65536) return -16'(SCORE_LIMIT_DEF);
        t  = b * d + r;
        cp = (t >= 0 ? t + d / 2 : t - d / 2) / d;
        if (cp > SCORE_LIMIT_DEF) cp = SCORE_LIMIT_DEF;
        if (cp < -SCORE_LIMIT_DEF) cp = -SCORE_LIMIT_DEF;
        return cp[15:0];
    endfunction

    function automatic void predict(input board_item_t it, input bit typed, input eval_t want);
        eval_t e;
        case (it.func)
            FN_WRITE: begin
                if (it.region == RG_FEAT && it.address < FEAT_DEPTH)
                    feat_mem[it.address] = it.data;
                else if (it.region == RG_FBIAS && it.address < MAX_HIDDEN_ONE_DEF)
                    fbias[it.address] = it.data;
                else if (it.region == RG_SW && it.address < SW_DEPTH)
                    sw_mem[it.address] = it.data;
                else if (it.region == RG_SBIAS && it.address < HIDDEN_TWO)
                    sbias[it.address] = it.data;
                else if (it.region == RG_OUTW && it.address < HIDDEN_TWO)
                    outw[it.address] = it.data;
            end
            FN_REFRESH: begin
                if (!p_loaded) begin
                    acc_ok = 0;
                end else begin
                    ksq[0] = it.wk;
                    ksq[1] = it.bk;
                    for (int i = 0; i < hid_n(); i++) begin
                        acc[0][i] = fbias[i];
                        acc[1][i] = fbias[i];
                    end
                    acc_ok = 1;
                end
            end
            FN_ADD: if (p_loaded) apply_piece(it.kind, it.color, it.square, 0);
            FN_PUT, FN_REMOVE: begin
                if (p_loaded && acc_ok) begin
                    if (p_fmt == FMT_BUCKET && it.kind == KIND_KING) acc_ok = 0;
                    else apply_piece(it.kind, it.color, it.square, it.func == FN_REMOVE);
                end
            end
            FN_EVAL: begin
                if (typed) begin
                    e = want;
                end else if (!p_loaded || !acc_ok) begin
                    e.score = '0;
                    e.valid = 1'b0;
                end else begin
                    e.score = predict_score(it.stm);
                    e.valid = 1'b1;
                end
                pending_scores.push_back(e);
            end
            default: ;
        endcase
    endfunction

    function automatic board_item_t random_item();
        board_item_t it;
        it.func    = 3'($urandom_range(0, 7));
        it.region  = 3'($urandom_range(0, 7));
        it.address = 24'($urandom);
        it.data    = 16'($urandom_range(0, 65534) - 32767);
        it.kind    = 3'($urandom_range(0, 7));
        it.color   = 1'($urandom);
        it.square  = 6'($urandom);
        it.wk      = 6'($urandom);
        it.bk      = 6'($urandom);
        it.stm     = 1'($urandom);
        return it;
    endfunction

    task automatic send_item(input board_item_t it, input bit typed, input eval_t want);
        @(negedge i_clk);
        item_if.func              = it.func;
        item_if.region            = it.region;
        item_if.address           = it.address;
        item_if.data              = it.data;
        item_if.piece_kind        = it.kind;
        item_if.piece_color       = it.color;
        item_if.square            = it.square;
        item_if.white_king_square = it.wk;
        item_if.black_king_square = it.bk;
        item_if.side_to_move      = it.stm;
        item_if.valid             = 1'b1;
        do @(posedge i_clk); while (!item_if.ready);
        predict(it, typed, want);
        if (it.func == FN_WRITE) n_writes++;
        else n_items++;
        @(negedge i_clk);
        item_if.valid = 1'b0;
    endtask

    task automatic write_word(input logic [2:0] rg, input int addr);
        board_item_t w;
        eval_t       none;
        w         = random_item();
        w.func    = FN_WRITE;
        w.region  = rg;
        w.address = 24'(addr);
        send_item(w, 0, none);
    endtask

    task automatic fill_columns(input board_item_t it);
        int f;
        int h;
        h = hid_n();
        for (int p = 0; p < 2; p++) begin
            if (!feat_index(it.kind, it.color, it.square, p, f)) continue;
            for (int i = 0; i < h; i++)
                if (!feat_mem.exists(f * h + i)) write_word(RG_FEAT, f * h + i);
        end
    endtask

    task automatic issue(input board_item_t it, input bit typed, input eval_t want);
        if (it.func == FN_ADD || it.func == FN_PUT || it.func == FN_REMOVE)
            fill_columns(it);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        send_item(it, typed, want);
    endtask

    task automatic settle();
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_FORMAT:   p_fmt    = val[1:0];
            CFG_WIDE:     p_wide   = val[0];
            CFG_ACT:      p_act    = int'(val[14:0]);
            CFG_HID:      p_hid    = int'(val[14:0]);
            CFG_OUT:      p_out    = int'(val[14:0]);
            CFG_OUT_BIAS: p_bias   = longint'($signed(val));
            CFG_LOADED:   p_loaded = val[0];
            default: ;
        endcase
    endtask

    function automatic dir_row_t mk_item(input logic [2:0] fn, input logic [2:0] rg,
                                         input logic [23:0] ad, input logic signed [15:0] dt,
                                         input logic [2:0] kd, input logic cl,
                                         input logic [5:0] sq, input logic [5:0] wk,
                                         input logic [5:0] bk, input logic stm);
        dir_row_t r;
        r.rk         = ROW_ITEM;
        r.it.func    = fn;
        r.it.region  = rg;
        r.it.address = ad;
        r.it.data    = dt;
        r.it.kind    = kd;
        r.it.color   = cl;
        r.it.square  = sq;
        r.it.wk      = wk;
        r.it.bk      = bk;
        r.it.stm     = stm;
        r.typed      = 0;
        r.want.score = '0;
        r.want.valid = 1'b0;
        r.cfg_idx    = CFG_FORMAT;
        r.cfg_val    = '0;
        return r;
    endfunction

    function automatic dir_row_t mk_zero_eval(input logic stm);
        dir_row_t r;
        r       = mk_item(FN_EVAL, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, stm);
        r.typed = 1;
        return r;
    endfunction

    function automatic dir_row_t mk_cfg(input logic [2:0] idx, input logic [31:0] val);
        dir_row_t r;
        r         = mk_item(FN_WRITE, RG_SPARE, 0, 0, 0, 0, 0, 0, 0, 0);
        r.rk      = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    task automatic run_phase(input int ph, input int n);
        logic [1:0]  fmts [NUM_PHASES];
        board_item_t pool [POOL_N];
        logic [5:0]  kings [2][2];
        board_item_t it;
        eval_t       none;
        int          r, eval_pct, sel;
        fmts = '{FMT_CLIPPED, FMT_UNCLIPPED, FMT_DUAL, FMT_BUCKET,
                 FMT_CLIPPED, FMT_BUCKET, FMT_DUAL, FMT_UNCLIPPED};
        settle();
        cfg_write(CFG_FORMAT, 32'(fmts[ph]));
        cfg_write(CFG_WIDE, (ph == 4 || ph == 5) ? 32'd1 : 32'd0);
        cfg_write(CFG_ACT, (ph == 0 || ph == 5) ? 32'd16384 : ph == 1 ? 32'd1 :
                  32'($urandom_range(1, 16384)));
        cfg_write(CFG_HID, ph == 0 ? 32'd16384 : (ph == 1 || ph == 5) ? 32'd1 :
                  32'($urandom_range(1, 16384)));
        cfg_write(CFG_OUT, (ph == 0 || ph == 5) ? 32'd16384 : ph == 1 ? 32'd1 :
                  32'($urandom_range(1, 16384)));
        cfg_write(CFG_OUT_BIAS, ph == 1 ? 32'h8000_0000 : ph == 5 ? 32'h7FFF_FFFF :
                  32'($urandom_range(0, 2000) - 1000));
        cfg_write(CFG_LOADED, 32'd1);
        eval_pct = p_wide ? 3 : 5;
        for (int i = 0; i < POOL_N; i++) begin
            pool[i]      = random_item();
            pool[i].kind = 3'($urandom_range(0, 5));
        end
        for (int i = 0; i < 2; i++) begin
            kings[i][0] = 6'($urandom);
            kings[i][1] = 6'($urandom);
        end
        it      = random_item();
        it.func = FN_REFRESH;
        it.wk   = kings[0][0];
        it.bk   = kings[0][1];
        issue(it, 0, none);
        for (int i = 0; i < 6; i++) begin
            it      = pool[$urandom_range(0, POOL_N - 1)];
            it.func = FN_ADD;
            issue(it, 0, none);
        end
        for (int k = 0; k < n; k++) begin
            if (ph == 2 && k == n / 2)
                while (pending_scores.size() != 0) @(posedge i_clk);
            r   = $urandom_range(0, 99);
            sel = $urandom_range(0, POOL_N - 1);
            it  = pool[sel];
            it.stm = 1'($urandom);
            if (r < 40) begin
                it.func = FN_PUT;
            end else if (r < 75) begin
                it.func = FN_REMOVE;
            end else if (r < 80) begin
                it.func = FN_ADD;
            end else if (r < 80 + eval_pct) begin
                it.func = FN_EVAL;
            end else if (r < 88) begin
                sel     = $urandom_range(0, 1);
                it.func = FN_REFRESH;
                it.wk   = kings[sel][0];
                it.bk   = kings[sel][1];
            end else if (r < 92) begin
                it.func = 3'($urandom_range(FN_ADD, FN_REMOVE));
                it.kind = 3'($urandom_range(6, 7));
            end else if (r < 95) begin
                it      = random_item();
                it.func = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
            end else if (r < 98) begin
                it      = random_item();
                it.func = FN_WRITE;
            end else begin
                it.func = $urandom_range(0, 1) ? FN_PUT : FN_REMOVE;
                it.kind = KIND_KING;
            end
            issue(it, 0, none);
        end
    endtask

    initial begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
            if (!calm && stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected score: expected none, actual %0d valid %0b",
                         $time, res_if.score, res_if.score_valid);
                fails++;
            end else begin
                got_want = pending_scores.pop_front();
                n_scores++;
                if (res_if.score !== got_want.score) begin
                    $display("%0t: score mismatch: expected %0d, actual %0d",
                             $time, got_want.score, res_if.score);
                    fails++;
                end
                if (res_if.score_valid !== got_want.valid) begin
                    $display("%0t: score_valid mismatch: expected %0b, actual %0b",
                             $time, got_want.valid, res_if.score_valid);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        eval_t none;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FORMAT;
        cfg_data      = '0;
        item_if.valid = 1'b0;
        item_if.func  = FN_WRITE;
        item_if.region = RG_FEAT;
        item_if.address = '0;
        item_if.data  = '0;
        item_if.piece_kind = '0;
        item_if.piece_color = 1'b0;
        item_if.square = '0;
        item_if.white_king_square = '0;
        item_if.black_king_square = '0;
        item_if.side_to_move = 1'b0;
        quiet    = 0;
        fails    = 0;
        n_items  = 0;
        n_writes = 0;
        n_scores = 0;
        calm     = 0;
        ksq[0]   = '0;
        ksq[1]   = '0;
        acc_ok   = 0;
        p_fmt    = FMT_CLIPPED;
        p_wide   = 1;
        p_act    = 1;
        p_hid    = 1;
        p_out    = 1;
        p_bias   = 0;
        p_loaded = 0;
        none.score = '0;
        none.valid = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < MAX_HIDDEN_ONE_DEF; i++) write_word(RG_FBIAS, i);
        for (int i = 0; i < SW_DEPTH; i++) write_word(RG_SW, i);
        for (int i = 0; i < HIDDEN_TWO; i++) begin
            write_word(RG_SBIAS, i);
            write_word(RG_OUTW, i);
        end

        dir_rows.push_back(mk_zero_eval(1'b0));
        dir_rows.push_back(mk_item(FN_REFRESH, RG_FEAT, 0, 0, 0, 0, 0, 6'd63, 6'd0, 0));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, 3'd0, 0, 6'd0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_ADD, RG_FEAT, 0, 0, 3'd4, 1, 6'd63, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_SPARE_A, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_SPARE_B, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_WRITE, RG_SPARE, 0, 16'sd5, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_WRITE, RG_FBIAS, 24'd256, 16'sd7, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_WRITE, RG_FEAT, 24'd10485759, 16'sd32767,
                                   0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_WRITE, RG_OUTW, 24'hFFFFFF, -16'sd32767,
                                   0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_WRITE, RG_SW, 24'd16384, 16'sd1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_cfg(CFG_LOADED, 32'd1));
        dir_rows.push_back(mk_item(FN_REFRESH, RG_FEAT, 0, 0, 0, 0, 0, 6'd4, 6'd60, 0));
        dir_rows.push_back(mk_item(FN_ADD, RG_FEAT, 0, 0, KIND_KING, 0, 6'd4, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, 3'd0, 0, 6'd12, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, 3'd3, 1, 6'd63, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_REMOVE, RG_FEAT, 0, 0, 3'd0, 0, 6'd12, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, 3'd6, 0, 6'd20, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_REMOVE, RG_FEAT, 0, 0, 3'd7, 1, 6'd21, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_EVAL, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_EVAL, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk_cfg(CFG_FORMAT, 32'(FMT_BUCKET)));
        dir_rows.push_back(mk_item(FN_REFRESH, RG_FEAT, 0, 0, 0, 0, 0, 6'd0, 6'd63, 0));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, 3'd2, 1, 6'd33, 0, 0, 0));
        dir_rows.push_back(mk_item(FN_EVAL, RG_FEAT, 0, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk_item(FN_PUT, RG_FEAT, 0, 0, KIND_KING, 0, 6'd5, 0, 0, 0));
        dir_rows.push_back(mk_zero_eval(1'b0));
        dir_rows.push_back(mk_item(FN_REMOVE, RG_FEAT, 0, 0, 3'd0, 0, 6'd8, 0, 0, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].rk == ROW_CFG) begin
                settle();
                cfg_write(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                issue(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == NUM_PHASES - 1);
            run_phase(ph, RANDOM_ITEMS / NUM_PHASES);
        end

        settle();
        $display("Ran %0d board items and %0d weight writes over %0d net settings",
                 n_items, n_writes, NUM_PHASES + 2);
        $display("Compared %0d scores, %0d mismatches", n_scores, fails);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
